/* hdl/bpsh_pkg.sv */
// ============================================================================
// bpsh_pkg: shared definitions for the binary pulse shaper
// Field widths, parameter defaults, item kinds and the lane control and
// status bundles used between the core and its pulse lanes.
// ============================================================================
package bpsh_pkg;

  // Parameter defaults.
  localparam int DEF_MAX_FRAME  = 1024;
  localparam int DEF_TAPS       = 25;
  localparam int DEF_OVERSAMPLE = 5;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int COEF_W   = 12;
  localparam int SAMPLE_W = 12;
  localparam int FL_W     = 11;
  // Symbol positions stay below the largest frame length plus two lane strides.
  localparam int SP_W     = 13;

  localparam logic [FL_W-1:0] FRAME_LEN_RESET = 11'd768;

  typedef enum logic [KIND_W-1:0] {
    KIND_COEF  = 2'd0,
    KIND_BIT   = 2'd1,
    KIND_START = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  // Broadcast from the core to every lane.
  typedef struct packed {
    logic                tick;
    logic                rewind;
    logic                coef_we;
    logic                bit_we;
    logic [INDEX_W-1:0]  index;
    logic                bit_value;
    logic [COEF_W-1:0]   coefficient;
    logic [FL_W-1:0]     frame_length;
  } lane_ctl_t;

  // Returned from each lane to the core.
  typedef struct packed {
    logic                past_end;
    logic [SAMPLE_W-1:0] term;
  } lane_stat_t;

endpackage

/* hdl/binary_raised_cosine_pulse_shaper_core.sv */
// ============================================================================
// binary_raised_cosine_pulse_shaper_core: binary raised-cosine pulse shaper
// Loads two impulse responses and a frame of bits, then on each emitting tick
// sends out one shaped 12-bit sample, oversampled by OVERSAMPLE.
// ============================================================================
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ------------------------------------
//  item      item_valid / item_stall   kind, index, bit_value, coefficient
//  result    result_valid/result_stall sample, frame_end
//  cfg       cfg_valid / cfg_ready     cfg_data (frame_length)
//
// One item is accepted per cycle while item_stall is low. Each emitting tick reads one coefficient in
// every lane's table copy; the registered read data is summed on the way into
// the result register on the next emitting tick, so ticks may come back to back.
// Reset is synchronous; the coefficient and frame bit stores are not cleared.
// A two-entry result buffer lets the core take items while a result waits;
// item_stall is raised only when both entries are full.
//
module binary_raised_cosine_pulse_shaper_core #(
  parameter int MAX_FRAME  = bpsh_pkg::DEF_MAX_FRAME,
  parameter int TAPS       = bpsh_pkg::DEF_TAPS,
  parameter int OVERSAMPLE = bpsh_pkg::DEF_OVERSAMPLE
) (
  input  logic                                clk,
  input  logic                                rst,
  // Item channel.
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [bpsh_pkg::KIND_W-1:0]         kind,
  input  logic [bpsh_pkg::INDEX_W-1:0]        index,
  input  logic                                bit_value,
  input  logic signed [bpsh_pkg::COEF_W-1:0]  coefficient,
  // Result channel.
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [bpsh_pkg::SAMPLE_W-1:0]       sample,
  output logic                                frame_end,
  // Configuration channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpsh_pkg::FL_W-1:0]           cfg_data
);

  localparam int LANES = (TAPS + OVERSAMPLE - 1) / OVERSAMPLE;
  localparam logic [bpsh_pkg::INDEX_W:0] TAPS_LIM  = (bpsh_pkg::INDEX_W + 1)'(TAPS);
  localparam logic [bpsh_pkg::SP_W-1:0]  FRAME_LIM = bpsh_pkg::SP_W'(MAX_FRAME);

  // Control registers.
  logic                           armed;
  logic                           frame_ready;
  logic [bpsh_pkg::FL_W-1:0]      frame_length;

  // Result buffer: the output register and the skid entry behind it.
  logic                           skid_valid;
  logic [bpsh_pkg::SAMPLE_W-1:0]  skid_sample;
  logic                           skid_end;

  logic                           accept;
  logic                           emit;
  logic                           done;
  logic                           rewind;
  logic                           out_take;
  logic [bpsh_pkg::SAMPLE_W-1:0]  pend_sum;

  bpsh_pkg::lane_ctl_t            lane_ctl;
  bpsh_pkg::lane_stat_t           lane_stat [LANES];

  assign item_stall = skid_valid;
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;

  // A tick emits only when the block was armed by an earlier tick and a frame
  // has been started; otherwise it merely arms the block.
  assign emit   = accept && (kind == bpsh_pkg::KIND_TICK) && armed && frame_ready;
  assign rewind = emit && done;

  // The frame ends when every lane has moved past the last symbol.
  always_comb begin
    done = 1'b1;
    for (int k = 0; k < LANES; k++) begin
      done = done && lane_stat[k].past_end;
    end
  end

  // The pending sample is the wrapping sum of the lanes' last lookups.
  always_comb begin
    pend_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      pend_sum = pend_sum + lane_stat[k].term;
    end
  end

  always_comb begin
    lane_ctl.tick         = emit;
    lane_ctl.rewind       = rewind;
    lane_ctl.coef_we      = accept && (kind == bpsh_pkg::KIND_COEF)
                            && ({1'b0, index} < TAPS_LIM);
    lane_ctl.bit_we       = accept && (kind == bpsh_pkg::KIND_BIT)
                            && (bpsh_pkg::SP_W'(index) < FRAME_LIM);
    lane_ctl.index        = index;
    lane_ctl.bit_value    = bit_value;
    lane_ctl.coefficient  = coefficient;
    lane_ctl.frame_length = frame_length;
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bpsh_lane #(
      .MAX_FRAME  (MAX_FRAME),
      .TAPS       (TAPS),
      .OVERSAMPLE (OVERSAMPLE),
      .LANE       (k)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (lane_ctl),
      .stat (lane_stat[k])
    );
  end

  // Frame control and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      frame_ready  <= 1'b0;
      frame_length <= bpsh_pkg::FRAME_LEN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_length <= cfg_data;
      end
      if (rewind) begin
        armed       <= 1'b0;
        frame_ready <= 1'b0;
      end else begin
        if (accept && (kind == bpsh_pkg::KIND_TICK)) begin
          armed <= 1'b1;
        end
        if (accept && (kind == bpsh_pkg::KIND_START)) begin
          frame_ready <= 1'b1;
        end
      end
    end
  end

  // Result buffer. A new transaction goes to the output register when it is
  // free or being taken, and to the skid entry otherwise. No item is taken
  // while the skid entry is full, so the two never fill at once.
  assign out_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end
      end else if (emit) begin
        if (!result_valid || out_take) begin
          result_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        sample    <= skid_sample;
        frame_end <= skid_end;
      end
    end else if (emit) begin
      if (!result_valid || out_take) begin
        sample    <= pend_sum;
        frame_end <= done;
      end else begin
        skid_sample <= pend_sum;
        skid_end    <= done;
      end
    end
  end

`ifndef SYNTH
  // The skid entry fills only behind a stalled result.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid entry filled while the output register was free");

  // A frame end leaves the block disarmed and waiting for a new start.
  a_rewind_clears: assert property (@(posedge clk) disable iff (rst)
    rewind |=> (!frame_ready && !armed))
    else $error("frame end did not clear the frame controls");

  // A result appears only after an emitting tick.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(emit))
    else $error("result transaction without an emitting tick");
`endif

endmodule

/* hdl/bpsh_ram.sv */
// ============================================================================
// bpsh_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read at the write address in
// the same cycle returns the old contents.
// ============================================================================
module bpsh_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bpsh_lane.sv */
// ============================================================================
// bpsh_lane: one staggered pulse lane
// Holds the lane's tap phase and symbol position, its copies of the frame bit
// store and the coefficient table, and the prefetched bit of its next symbol.
// ============================================================================
module bpsh_lane #(
  parameter int MAX_FRAME  = bpsh_pkg::DEF_MAX_FRAME,
  parameter int TAPS       = bpsh_pkg::DEF_TAPS,
  parameter int OVERSAMPLE = bpsh_pkg::DEF_OVERSAMPLE,
  parameter int LANE       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bpsh_pkg::lane_ctl_t    ctl,
  output bpsh_pkg::lane_stat_t   stat
);

  localparam int LANES = (TAPS + OVERSAMPLE - 1) / OVERSAMPLE;
  localparam int FAW   = $clog2(MAX_FRAME);
  localparam int CDEP  = 2 * TAPS;
  localparam int CAW   = $clog2(CDEP);
  localparam int PHW   = $clog2(TAPS) + 2;
  localparam int SPW   = bpsh_pkg::SP_W;

  localparam logic signed [PHW-1:0] PH_START = PHW'(-(LANE * OVERSAMPLE));
  localparam logic signed [PHW-1:0] PH_LAST  = PHW'(TAPS - 1);
  localparam logic signed [PHW-1:0] PH_ZERO  = '0;
  localparam logic signed [PHW-1:0] PH_ONE   = PHW'(1);
  localparam logic [SPW-1:0] SP_START = SPW'(LANE);
  localparam logic [SPW-1:0] SP_STEP  = SPW'(LANES);
  localparam logic [SPW-1:0] SP_MAXF  = SPW'(MAX_FRAME);
  localparam logic [CAW-1:0] ROW_OFS  = CAW'(TAPS);
  localparam logic           HOME_IN  = (LANE < MAX_FRAME);

  logic signed [PHW-1:0] ph;
  logic [SPW-1:0]        sp;
  logic                  cur_bit;
  logic                  home_bit;
  logic                  active;
  logic                  lw_valid;
  logic [bpsh_pkg::INDEX_W-1:0] lw_addr;
  logic                  lw_bit;

  logic [SPW-1:0]        pf_sp;
  logic                  pf_oob;
  logic                  fr_rdata;
  logic                  nxt_bit;
  logic                  wrap;
  logic signed [PHW-1:0] ph_adv;
  logic [SPW-1:0]        sp_adv;
  logic                  bit_adv;
  logic signed [PHW-1:0] ph_next;
  logic [SPW-1:0]        sp_next;
  logic                  bit_next;
  logic                  active_next;
  logic [SPW-1:0]        fl_ext;
  logic [CAW-1:0]        c_raddr;
  logic [CAW-1:0]        c_waddr;
  logic [bpsh_pkg::COEF_W-1:0] c_rdata;

  assign fl_ext = SPW'(ctl.frame_length);

  // The frame bit of the lane's next symbol is read ahead every cycle. A
  // write in the previous cycle is not yet in the read data and is forwarded.
  assign pf_sp  = sp + SP_STEP;
  assign pf_oob = (pf_sp >= SP_MAXF);
  assign nxt_bit = pf_oob ? 1'b0
                 : ((lw_valid && (SPW'(lw_addr) == pf_sp)) ? lw_bit : fr_rdata);

  bpsh_ram #(
    .WIDTH(1),
    .DEPTH(MAX_FRAME)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ctl.bit_we),
    .waddr (FAW'(ctl.index)),
    .wdata (ctl.bit_value),
    .re    (1'b1),
    .raddr (pf_sp[FAW-1:0]),
    .rdata (fr_rdata)
  );

  always_comb begin
    wrap    = (ph == PH_LAST);
    ph_adv  = wrap ? PH_ZERO : (ph + PH_ONE);
    sp_adv  = wrap ? pf_sp : sp;
    bit_adv = wrap ? nxt_bit : cur_bit;
    if (ctl.rewind) begin
      ph_next  = PH_START;
      sp_next  = SP_START;
      bit_next = HOME_IN ? home_bit : 1'b0;
    end else begin
      ph_next  = ph_adv;
      sp_next  = sp_adv;
      bit_next = bit_adv;
    end
    active_next = (ph_next >= PH_ZERO) && (ph_next <= PH_LAST) && (sp_next < fl_ext);
  end

  assign c_raddr = active_next
                 ? (CAW'(unsigned'(ph_next)) + (bit_next ? ROW_OFS : '0)) : '0;
  assign c_waddr = CAW'(ctl.index) + (ctl.bit_value ? ROW_OFS : '0);

  bpsh_ram #(
    .WIDTH(bpsh_pkg::COEF_W),
    .DEPTH(CDEP)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ctl.coef_we),
    .waddr (c_waddr),
    .wdata (ctl.coefficient),
    .re    (ctl.tick),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ph       <= PH_START;
      sp       <= SP_START;
      active   <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= ctl.bit_we;
      if (ctl.tick) begin
        ph     <= ph_next;
        sp     <= sp_next;
        active <= active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    lw_addr <= ctl.index;
    lw_bit  <= ctl.bit_value;
    if (ctl.tick) begin
      cur_bit <= bit_next;
    end else if (ctl.bit_we && (SPW'(ctl.index) == sp)) begin
      cur_bit <= ctl.bit_value;
    end
    if (ctl.bit_we && (SPW'(ctl.index) == SP_START)) begin
      home_bit <= ctl.bit_value;
    end
  end

  assign stat.past_end = (sp_adv >= fl_ext);
  assign stat.term     = active ? c_rdata : '0;

endmodule

/* test/tb_binary_raised_cosine_pulse_shaper_core.sv */
// ============================================================================
// tb_binary_raised_cosine_pulse_shaper_core: pulse shaper core testbench
// Loads both impulse responses and the low part of the frame store, runs frames
// at the reset length and at the extreme lengths, then sends random traffic
// under several sender and receiver pacing schemes. An in-line copy of the
// shaper predicts each emitted sample and frame end; every result transaction
// is checked against the oldest prediction.
// ============================================================================
module tb_binary_raised_cosine_pulse_shaper_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS       = bpsh_pkg::DEF_TAPS;
  localparam int MAX_FRAME  = bpsh_pkg::DEF_MAX_FRAME;
  localparam int OVERSAMPLE = bpsh_pkg::DEF_OVERSAMPLE;
  localparam int KIND_W     = bpsh_pkg::KIND_W;
  localparam int INDEX_W    = bpsh_pkg::INDEX_W;
  localparam int COEF_W     = bpsh_pkg::COEF_W;
  localparam int SAMPLE_W   = bpsh_pkg::SAMPLE_W;
  localparam int FL_W       = bpsh_pkg::FL_W;
  // Number of staggered pulse lanes; each lane covers one symbol's pulse.
  localparam int LANES      = (TAPS + OVERSAMPLE - 1) / OVERSAMPLE;
  // Cycles allowed for the read-and-sum pipeline to settle before a
  // configuration write or the end of the run.
  localparam int SETTLE_CYCLES = 16;
  // Frame bits loaded up front. Every frame that runs far enough to reach a
  // symbol keeps its length below this, so no symbol reads an unwritten bit.
  localparam int LOADED_BITS = 128;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } shaped_out_t;

  // DUT connections.
  logic                       clk;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  logic [KIND_W-1:0]          kind;
  logic [INDEX_W-1:0]         index;
  logic                       bit_value;
  logic signed [COEF_W-1:0]   coefficient;
  logic                       result_valid;
  logic                       result_stall;
  logic [SAMPLE_W-1:0]        sample;
  logic                       frame_end;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [FL_W-1:0]            cfg_data;

  // Shadow copy of the shaper state, advanced once per accepted item.
  logic [COEF_W-1:0]   coef_mem [2][TAPS];
  logic                bit_mem [MAX_FRAME];
  int                  tap_ph [LANES];
  int                  sym_pos [LANES];
  logic [SAMPLE_W-1:0] pending_q;
  logic                frame_ready_q;
  logic                armed_q;
  logic [FL_W-1:0]     frame_len_q;
  int                  frames_done;

  // Predicted result transactions, oldest first.
  shaped_out_t sample_queue[$];
  int          errors;

  // Pacing knobs, in percent per cycle.
  int idle_pct;
  int stall_pct;

  binary_raised_cosine_pulse_shaper_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .index        (index),
    .bit_value    (bit_value),
    .coefficient  (coefficient),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Put every lane back at its starting offset: lane k starts k symbols in and
  // k*OVERSAMPLE ticks behind, so the pulses overlap in a staggered pattern.
  function automatic void rewind_lanes();
    for (int l = 0; l < LANES; l++) begin
      tap_ph[l]  = -l * OVERSAMPLE;
      sym_pos[l] = l;
    end
  endfunction

  // Advance the shadow state by one accepted item. An emitting tick pushes the
  // sample that was formed on the previous emitting tick, then moves the lanes
  // and forms the next sample as the wrapping sum of the active lanes' taps.
  function automatic void shape_item(bpsh_pkg::kind_t k, logic [INDEX_W-1:0] idx,
                                     logic b, logic [COEF_W-1:0] c);
    shaped_out_t         res;
    logic [SAMPLE_W-1:0] acc;
    logic                sym_bit;
    bit                  done;
    case (k)
      bpsh_pkg::KIND_COEF: begin
        if (idx < TAPS) coef_mem[b][idx] = c;
      end
      bpsh_pkg::KIND_BIT: begin
        if (idx < MAX_FRAME) bit_mem[idx] = b;
      end
      bpsh_pkg::KIND_START: begin
        frame_ready_q = 1'b1;
      end
      default: begin
        if (!(armed_q && frame_ready_q)) begin
          // A tick that cannot emit only arms the block.
          armed_q = 1'b1;
        end else begin
          res.sample = pending_q;
          done = 1'b1;
          for (int l = 0; l < LANES; l++) begin
            tap_ph[l]++;
            if (tap_ph[l] >= TAPS) begin
              tap_ph[l] = 0;
              sym_pos[l] += LANES;
            end
            if (sym_pos[l] < int'(frame_len_q)) done = 1'b0;
          end
          if (done) begin
            rewind_lanes();
            frame_ready_q = 1'b0;
            armed_q = 1'b0;
            frames_done++;
          end
          acc = '0;
          for (int l = 0; l < LANES; l++) begin
            if (tap_ph[l] >= 0 && tap_ph[l] < TAPS && sym_pos[l] < int'(frame_len_q)) begin
              // Symbols past the end of the store read as bit zero.
              sym_bit = 1'b0;
              if (sym_pos[l] < MAX_FRAME) sym_bit = bit_mem[sym_pos[l]];
              acc += coef_mem[sym_bit][tap_ph[l]];
            end
          end
          pending_q = acc;
          res.frame_end = done;
          sample_queue.push_back(res);
        end
      end
    endcase
  endfunction

  // Send one item transaction. Inputs change on the falling edge; the item is
  // taken at the first rising edge where the core does not stall it. Valid is
  // left high so that the next call can follow back to back.
  task automatic send_item(bpsh_pkg::kind_t k, logic [INDEX_W-1:0] idx, logic b,
                           logic [COEF_W-1:0] c);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid  = 1'b1;
    kind        = k;
    index       = idx;
    bit_value   = b;
    coefficient = c;
    do @(posedge clk); while (item_stall);
    shape_item(k, idx, b, c);
  endtask

  // Ticks and starts carry random, unused payload so every input bit toggles.
  task automatic send_tick();
    send_item(bpsh_pkg::KIND_TICK, INDEX_W'($urandom), 1'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_start();
    send_item(bpsh_pkg::KIND_START, INDEX_W'($urandom), 1'($urandom), COEF_W'($urandom));
  endtask

  // Stop sending and wait until every predicted result has been received.
  task automatic drain_results();
    @(negedge clk);
    item_valid = 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
  endtask

  // The frame length register is only written while the core is idle: no
  // result outstanding and the internal pipeline given time to empty.
  task automatic write_frame_length(logic [FL_W-1:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = len;
    do @(posedge clk); while (!cfg_ready);
    frame_len_q = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Start a frame and tick until the shadow state reports that it ended.
  task automatic run_frame();
    int target;
    target = frames_done + 1;
    send_start();
    while (frames_done < target) send_tick();
  endtask

  // Fill both impulse responses, with the coefficient extremes on the first
  // taps, and the low frame bits that the frames below can reach. Tap indexes
  // past the table end must be ignored.
  task automatic test_load_stores();
    logic [COEF_W-1:0] c;
    for (int r = 0; r < 2; r++) begin
      for (int t = 0; t < TAPS; t++) begin
        case (t)
          0:       c = 12'h800;
          1:       c = 12'h7ff;
          2:       c = 12'h000;
          3:       c = 12'hfff;
          default: c = COEF_W'($urandom);
        endcase
        send_item(bpsh_pkg::KIND_COEF, INDEX_W'(t), 1'(r), c);
      end
    end
    send_item(bpsh_pkg::KIND_COEF, INDEX_W'(TAPS), 1'b1, 12'h5a5);
    send_item(bpsh_pkg::KIND_COEF, '1, 1'b0, 12'ha5a);
    for (int a = 0; a < LOADED_BITS; a++) begin
      send_item(bpsh_pkg::KIND_BIT, INDEX_W'(a), 1'($urandom), '0);
    end
  endtask

  // Ticks before any start only arm the core and produce nothing. A second
  // start in the middle of a frame changes nothing. The frame length is still
  // the reset value here, and the frame is run part way.
  task automatic test_reset_length_frame();
    send_tick();
    send_tick();
    send_item(bpsh_pkg::KIND_START, '0, 1'b0, '0);
    repeat (10) send_tick();
    send_start();
    repeat (30) send_tick();
  endtask

  // Zero length ends the frame on the first emitting tick; lengths of one and
  // two end once the last lane has passed them. The largest lengths are run
  // part way, and a short length then brings that frame to its end.
  task automatic test_frame_length_extremes();
    logic [FL_W-1:0] lens [3];
    lens = '{11'd0, 11'd1, 11'd2};
    foreach (lens[i]) begin
      write_frame_length(lens[i]);
      run_frame();
    end
    write_frame_length(11'd2047);
    send_start();
    repeat (60) send_tick();
    write_frame_length(11'd1024);
    repeat (40) send_tick();
    write_frame_length(11'd24);
    run_frame();
  endtask

  // Mostly start-and-tick frames with random content, mixed with table and
  // frame bit rewrites mid-frame, out-of-range taps and stray starts.
  task automatic test_random_traffic(int n_items, int send_idle, int recv_stall);
    int                 count;
    int                 r;
    logic [INDEX_W-1:0] idx;
    logic [COEF_W-1:0]  c;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    count = 0;
    while (count < n_items) begin
      if (count == 0 || $urandom_range(299) == 0) begin
        r = $urandom_range(99);
        if (r < 10)      write_frame_length('0);
        else if (r < 15) write_frame_length(FL_W'($urandom_range(LOADED_BITS - 1, 65)));
        else if (r < 35) write_frame_length(FL_W'($urandom_range(64, 13)));
        else             write_frame_length(FL_W'($urandom_range(12, 1)));
      end
      // Occasionally hold the sender until the result side has caught up.
      if ($urandom_range(199) == 0) drain_results();
      r = $urandom_range(99);
      if (r < 70) begin
        send_tick();
        count++;
      end else if (r < 76) begin
        send_start();
        count++;
      end else if (r < 88) begin
        idx = ($urandom_range(9) == 0) ? INDEX_W'($urandom) : INDEX_W'($urandom_range(TAPS - 1));
        case ($urandom_range(7))
          0:       c = 12'h800;
          1:       c = 12'h7ff;
          default: c = COEF_W'($urandom);
        endcase
        send_item(bpsh_pkg::KIND_COEF, idx, 1'($urandom), c);
        if (idx < TAPS) count++;
      end else begin
        idx = ($urandom_range(9) < 7) ? INDEX_W'($urandom_range(15)) : INDEX_W'($urandom);
        send_item(bpsh_pkg::KIND_BIT, idx, 1'($urandom), COEF_W'($urandom));
        count++;
      end
    end
  endtask

  // The result side stalls at random at the rate currently selected.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      result_stall = (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Every result transaction is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    shaped_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (sample_queue.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, sample=%h frame_end=%b",
                 $time, sample, frame_end);
      end else begin
        want = sample_queue.pop_front();
        if (sample !== want.sample) begin
          errors++;
          $display("%0t: sample expected %h got %h", $time, want.sample, sample);
        end
        if (frame_end !== want.frame_end) begin
          errors++;
          $display("%0t: frame_end expected %b got %b", $time, want.frame_end, frame_end);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    kind          = bpsh_pkg::KIND_TICK;
    index         = '0;
    bit_value     = 1'b0;
    coefficient   = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    errors        = 0;
    frames_done   = 0;
    pending_q     = '0;
    frame_ready_q = 1'b0;
    armed_q       = 1'b0;
    frame_len_q   = bpsh_pkg::FRAME_LEN_RESET;
    rewind_lanes();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_load_stores();
    test_reset_length_frame();
    test_frame_length_extremes();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 45, 0);
    test_random_traffic(350, 0, 45);
    test_random_traffic(350, 17, 17);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit, far above the slowest correct run.
  initial begin
    #400_000;
    $display("simulation failed");
    $finish;
  end

endmodule
